/* rtl/core/qpd_pkg.sv */
package qpd_pkg;

    localparam int TARGET_W = 32;
    localparam int SPEED_W  = 16;
    localparam int DUTY_W   = 8;
    localparam int RATE_W   = 12;
    localparam int MARGIN_W = 16;
    localparam int IZ_W     = 20;
    localparam int POS_W    = 32;

    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 80;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 20;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;

    // input commands
    localparam logic [1:0] CMD_ENC_A = 2'd0;
    localparam logic [1:0] CMD_ENC_B = 2'd1;
    localparam logic [1:0] CMD_SET   = 2'd2;
    localparam logic [1:0] CMD_DRIVE = 2'd3;

    // queued work kinds
    localparam logic [1:0] KIND_UP    = 2'd0;
    localparam logic [1:0] KIND_DOWN  = 2'd1;
    localparam logic [1:0] KIND_SET   = 2'd2;
    localparam logic [1:0] KIND_DRIVE = 2'd3;

    // drive direction
    localparam logic [1:0] DIR_OFF = 2'd0;
    localparam logic [1:0] DIR_FWD = 2'd1;
    localparam logic [1:0] DIR_REV = 2'd2;

    // configuration register indices
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_ZERO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_Q8    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE_DUTY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE_MS   = 3'd4;

    localparam logic [MARGIN_W-1:0] MARGIN_RST     = 16'd10;
    localparam logic [IZ_W-1:0]     INV_ZERO_RST   = 20'd0;
    localparam logic [RATE_W-1:0]   RATE_RST       = 12'd256;
    localparam logic [DUTY_W-1:0]   BRAKE_DUTY_RST = 8'd50;

    typedef struct packed {
        logic [1:0]                 kind;
        logic signed [TARGET_W-1:0] target;
        logic [DUTY_W-1:0]          duty;
    } work_t;

    typedef struct packed {
        logic [MARGIN_W-1:0] margin;
        logic [IZ_W-1:0]     inv_zero;
        logic [DUTY_W-1:0]   brake_duty;
    } back_cfg_t;

    typedef struct packed {
        logic                    in_fwd;
        logic                    in_rev;
        logic [DUTY_W-1:0]       duty;
        logic                    timed_pulse;
        logic signed [POS_W-1:0] position;
        logic signed [POS_W-1:0] target_now;
        logic                    last;
    } result_t;

endpackage

/* rtl/core/quadrature_position_drive_top.sv */
// channel  | direction | handshake          | payload
// s_       | in        | s_tvalid/s_tready  | s_tuser command, s_tdata encoder/target/speed
// m_       | out       | m_tvalid/m_tready  | m_tdata bridge/duty/position/target, m_tlast
// cfg_     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one transaction per cycle sustained while m_tready is high; a drive update that lands
// in the dead band gives two results and holds the execute stage for the second one
// from s_ acceptance to m_tvalid an item passes the queue write and the execute register
// with m_tready low the output register and the two-entry queue take three
// transactions, then s_tready drops
// synchronous active-low reset clears count, target, direction, duty, queue; cfg to defaults
module quadrature_position_drive_top #(
    parameter int COUNT_BITS = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // enc_a, enc_b, target_pos, speed_req
    input  logic [qpd_pkg::S_TDATA_W-1:0]    s_tdata,
    // command
    input  logic [qpd_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // in_fwd, in_rev, duty, timed_pulse, position, target_now
    output logic [qpd_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                             m_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [qpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [qpd_pkg::CFG_DAT_W-1:0]    cfg_data
);

    logic [qpd_pkg::MARGIN_W-1:0] margin_reg;
    logic [qpd_pkg::IZ_W-1:0]     inv_zero_reg;
    logic [qpd_pkg::RATE_W-1:0]   rate_reg;
    logic [qpd_pkg::DUTY_W-1:0]   brake_duty_reg;

    qpd_pkg::back_cfg_t cfg;
    qpd_pkg::work_t     push_data, pop_data;
    qpd_pkg::result_t   res;
    logic               push_valid, push_ready, pop_valid, pop_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            margin_reg     <= qpd_pkg::MARGIN_RST;
            inv_zero_reg   <= qpd_pkg::INV_ZERO_RST;
            rate_reg       <= qpd_pkg::RATE_RST;
            brake_duty_reg <= qpd_pkg::BRAKE_DUTY_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                qpd_pkg::REG_MARGIN:     margin_reg     <= cfg_data[qpd_pkg::MARGIN_W-1:0];
                qpd_pkg::REG_INV_ZERO:   inv_zero_reg   <= cfg_data[qpd_pkg::IZ_W-1:0];
                qpd_pkg::REG_RATE_Q8:    rate_reg       <= cfg_data[qpd_pkg::RATE_W-1:0];
                qpd_pkg::REG_BRAKE_DUTY: brake_duty_reg <= cfg_data[qpd_pkg::DUTY_W-1:0];
                // pulse length is timed outside the block
                qpd_pkg::REG_BRAKE_MS:   ;
                default:                 ;
            endcase
        end
    end

    assign cfg.margin     = margin_reg;
    assign cfg.inv_zero   = inv_zero_reg;
    assign cfg.brake_duty = brake_duty_reg;

    qpd_front u_front (
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .command    (s_tuser[1:0]),
        .enc_a      (s_tdata[0]),
        .enc_b      (s_tdata[1]),
        .target_pos ($signed(s_tdata[33:2])),
        .speed_req  ($signed(s_tdata[49:34])),
        .rate_q8    (rate_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    qpd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   (push_data),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_data  (pop_data)
    );

    qpd_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (pop_valid),
        .in_ready  (pop_ready),
        .in_data   (pop_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    assign m_tdata = {5'b0, res.target_now, res.position, res.timed_pulse,
                      res.duty, res.in_rev, res.in_fwd};
    assign m_tlast = res.last;

endmodule

/* rtl/core/qpd_front.sv */
module qpd_front (
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           command,
    input  logic                                 enc_a,
    input  logic                                 enc_b,
    input  logic signed [qpd_pkg::TARGET_W-1:0]  target_pos,
    input  logic signed [qpd_pkg::SPEED_W-1:0]   speed_req,
    input  logic [qpd_pkg::RATE_W-1:0]           rate_q8,
    output logic                                 push_valid,
    input  logic                                 push_ready,
    output qpd_pkg::work_t                       push_data
);

    logic [qpd_pkg::SPEED_W-1:0]                  speed_mag;
    logic [qpd_pkg::SPEED_W+qpd_pkg::RATE_W-1:0]  product;
    logic [qpd_pkg::DUTY_W-1:0]                   duty_sat;
    logic                                         count_up;

    // |speed| * rate / 256, saturated
    always_comb begin
        speed_mag = speed_req[qpd_pkg::SPEED_W-1]
                  ? qpd_pkg::SPEED_W'(-speed_req) : qpd_pkg::SPEED_W'(speed_req);
        product   = (qpd_pkg::SPEED_W+qpd_pkg::RATE_W)'(speed_mag)
                  * (qpd_pkg::SPEED_W+qpd_pkg::RATE_W)'(rate_q8);
        duty_sat  = (|product[qpd_pkg::SPEED_W+qpd_pkg::RATE_W-1:16])
                  ? {qpd_pkg::DUTY_W{1'b1}} : product[15:8];
    end

    always_comb begin
        count_up = (enc_a == enc_b);
        push_data.target = target_pos;
        push_data.duty   = duty_sat;
        unique case (command)
            qpd_pkg::CMD_ENC_A: begin
                push_data.kind = count_up ? qpd_pkg::KIND_UP : qpd_pkg::KIND_DOWN;
            end
            qpd_pkg::CMD_ENC_B: begin
                push_data.kind = count_up ? qpd_pkg::KIND_DOWN : qpd_pkg::KIND_UP;
            end
            qpd_pkg::CMD_SET: begin
                push_data.kind = qpd_pkg::KIND_SET;
            end
            default: begin
                push_data.kind = qpd_pkg::KIND_DRIVE;
            end
        endcase
    end

    assign push_valid = in_valid;
    assign in_ready   = push_ready;

endmodule

/* rtl/core/qpd_queue.sv */
module qpd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  qpd_pkg::work_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output qpd_pkg::work_t out_data
);

    qpd_pkg::work_t                    mem [qpd_pkg::QUEUE_DEPTH];
    logic [qpd_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [qpd_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [qpd_pkg::QUEUE_PTR_W:0]     fill_reg, fill_next;
    logic                              push, pop;

    assign in_ready  = (fill_reg != (qpd_pkg::QUEUE_PTR_W+1)'(qpd_pkg::QUEUE_DEPTH));
    assign out_valid = (fill_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

endmodule

/* rtl/core/qpd_back.sv */
module qpd_back #(
    parameter int COUNT_BITS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  qpd_pkg::back_cfg_t cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  qpd_pkg::work_t     in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output qpd_pkg::result_t   out_data
);

    localparam int XW = (COUNT_BITS > qpd_pkg::TARGET_W) ? COUNT_BITS : qpd_pkg::TARGET_W;

    logic signed [COUNT_BITS-1:0]        count_reg, count_next;
    logic signed [qpd_pkg::TARGET_W-1:0] goal_reg, goal_next;
    logic [1:0]                          dir_reg, dir_next;
    logic [qpd_pkg::DUTY_W-1:0]          held_reg, held_next;
    logic                                pend_reg, pend_next;
    logic                                out_valid_reg, out_valid_next;
    qpd_pkg::result_t                    out_reg, out_next;

    logic                                out_free, pop;
    logic signed [XW-1:0]                cnt_x, goal_x, half_x;
    logic signed [qpd_pkg::TARGET_W-1:0] iz_goal, goal_eff;
    logic                                swap_goal, gt, eq, near, brake;
    logic [XW-1:0]                       hi, lo, diff;
    logic signed [XW-1:0]                pos_x, cur_x;
    logic [1:0]                          rev_dir;
    qpd_pkg::result_t                    first_res, second_res;

    assign out_free = !out_valid_reg || out_ready;
    assign pop      = !pend_reg && in_valid && out_free;
    assign in_ready = !pend_reg && out_free;

    // drive update decision
    always_comb begin
        iz_goal   = qpd_pkg::TARGET_W'(cfg.inv_zero);
        cnt_x     = XW'(count_reg);
        half_x    = $signed(XW'(cfg.inv_zero[qpd_pkg::IZ_W-1:1]));
        swap_goal = (cnt_x > half_x) && (goal_reg == '0);
        goal_eff  = swap_goal ? iz_goal : goal_reg;
        goal_x    = XW'(goal_eff);
        gt        = cnt_x > goal_x;
        eq        = cnt_x == goal_x;
        hi        = gt ? cnt_x : goal_x;
        lo        = gt ? goal_x : cnt_x;
        diff      = hi - lo;
        near      = diff < XW'(cfg.margin);
        brake     = (in_data.kind == qpd_pkg::KIND_DRIVE) && near;
        unique case (dir_reg)
            qpd_pkg::DIR_FWD: rev_dir = qpd_pkg::DIR_REV;
            qpd_pkg::DIR_REV: rev_dir = qpd_pkg::DIR_FWD;
            default:          rev_dir = qpd_pkg::DIR_OFF;
        endcase
    end

    always_comb begin
        count_next = count_reg;
        goal_next  = goal_reg;
        dir_next   = dir_reg;
        held_next  = held_reg;
        unique case (in_data.kind)
            qpd_pkg::KIND_UP: begin
                count_next = count_reg + COUNT_BITS'(1);
            end
            qpd_pkg::KIND_DOWN: begin
                count_next = count_reg - COUNT_BITS'(1);
            end
            qpd_pkg::KIND_SET: begin
                goal_next = in_data.target;
            end
            default: begin
                goal_next = goal_eff;
                if (near) begin
                    dir_next  = qpd_pkg::DIR_OFF;
                    held_next = '0;
                    if (goal_eff == iz_goal) begin
                        goal_next  = '0;
                        count_next = count_reg - COUNT_BITS'(cfg.inv_zero);
                    end
                end else if (!gt && !eq) begin
                    dir_next  = qpd_pkg::DIR_FWD;
                    held_next = in_data.duty;
                end else if (gt) begin
                    dir_next  = qpd_pkg::DIR_REV;
                    held_next = in_data.duty;
                end
            end
        endcase
    end

    always_comb begin
        pos_x = XW'(count_next);
        cur_x = XW'(count_reg);
        if (brake) begin
            first_res.in_fwd      = (rev_dir == qpd_pkg::DIR_FWD);
            first_res.in_rev      = (rev_dir == qpd_pkg::DIR_REV);
            first_res.duty        = cfg.brake_duty;
            first_res.timed_pulse = 1'b1;
            first_res.position    = cur_x[qpd_pkg::POS_W-1:0];
            first_res.target_now  = goal_eff;
            first_res.last        = 1'b0;
        end else begin
            first_res.in_fwd      = (dir_next == qpd_pkg::DIR_FWD);
            first_res.in_rev      = (dir_next == qpd_pkg::DIR_REV);
            first_res.duty        = held_next;
            first_res.timed_pulse = 1'b0;
            first_res.position    = pos_x[qpd_pkg::POS_W-1:0];
            first_res.target_now  = goal_next;
            first_res.last        = 1'b1;
        end
        // motor off after the brake pulse, state already settled
        second_res.in_fwd      = 1'b0;
        second_res.in_rev      = 1'b0;
        second_res.duty        = '0;
        second_res.timed_pulse = 1'b0;
        second_res.position    = cur_x[qpd_pkg::POS_W-1:0];
        second_res.target_now  = goal_reg;
        second_res.last        = 1'b1;
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        pend_next      = pend_reg;
        priority if (pend_reg && out_free) begin
            out_valid_next = 1'b1;
            out_next       = second_res;
            pend_next      = 1'b0;
        end else if (pop) begin
            out_valid_next = 1'b1;
            out_next       = first_res;
            pend_next      = brake;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            goal_reg      <= '0;
            dir_reg       <= qpd_pkg::DIR_OFF;
            held_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                count_reg <= count_next;
                goal_reg  <= goal_next;
                dir_reg   <= dir_next;
                held_reg  <= held_next;
            end
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

/* tb/quadrature_position_drive_checker.sv */
`timescale 1ns / 1ps

module quadrature_position_drive_checker
    import qpd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tlast,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output int                   mismatches,
    output int                   outstanding
);

    result_t drive_results_due[$];

    logic signed [POS_W-1:0] count_q;
    logic signed [POS_W-1:0] goal_q;
    logic [1:0]              dir_q;
    logic [DUTY_W-1:0]       held_duty_q;
    logic [MARGIN_W-1:0]     margin_q;
    logic [IZ_W-1:0]         inv_zero_q;
    logic [RATE_W-1:0]       rate_q;
    logic [DUTY_W-1:0]       brake_duty_q;

    function automatic result_t bridge_state(input logic [1:0] dir, input logic [DUTY_W-1:0] duty,
                                             input logic pulse, input logic last);
        result_t r;
        r.in_fwd      = (dir == DIR_FWD);
        r.in_rev      = (dir == DIR_REV);
        r.duty        = duty;
        r.timed_pulse = pulse;
        r.position    = count_q;
        r.target_now  = goal_q;
        r.last        = last;
        return r;
    endfunction

    task automatic advance_drive(input logic [1:0] cmd, input logic a, input logic b,
                                 input logic signed [TARGET_W-1:0] tgt,
                                 input logic signed [SPEED_W-1:0] spd);
        logic       up;
        longint     c;
        longint     g;
        longint     iz;
        longint     diff;
        longint     mag;
        logic [1:0] rev;
        case (cmd)
            CMD_ENC_A, CMD_ENC_B: begin
                up = (a == b);
                if (cmd == CMD_ENC_B) up = !up;
                count_q = up ? count_q + 1 : count_q - 1;
                drive_results_due.push_back(bridge_state(dir_q, held_duty_q, 1'b0, 1'b1));
            end
            CMD_SET: begin
                goal_q = tgt;
                drive_results_due.push_back(bridge_state(dir_q, held_duty_q, 1'b0, 1'b1));
            end
            default: begin
                iz = inv_zero_q;
                c  = count_q;
                // past half the reverse zero with no target: head for the offset
                if (c > (iz >> 1) && goal_q == 0) goal_q = {12'd0, inv_zero_q};
                g    = goal_q;
                diff = (c > g) ? c - g : g - c;
                if (diff < longint'(margin_q)) begin
                    rev = (dir_q == DIR_FWD) ? DIR_REV : (dir_q == DIR_REV) ? DIR_FWD : DIR_OFF;
                    drive_results_due.push_back(bridge_state(rev, brake_duty_q, 1'b1, 1'b0));
                    dir_q       = DIR_OFF;
                    held_duty_q = '0;
                    if (g == iz) begin
                        goal_q  = '0;
                        count_q = count_q - {12'd0, inv_zero_q};
                    end
                    drive_results_due.push_back(bridge_state(DIR_OFF, '0, 1'b0, 1'b1));
                end else begin
                    mag = spd;
                    if (mag < 0) mag = -mag;
                    mag = (mag * longint'(rate_q)) >> 8;
                    if (mag > 255) mag = 255;
                    if (g > c) begin
                        dir_q       = DIR_FWD;
                        held_duty_q = mag[DUTY_W-1:0];
                    end else if (c > g) begin
                        dir_q       = DIR_REV;
                        held_duty_q = mag[DUTY_W-1:0];
                    end
                    drive_results_due.push_back(bridge_state(dir_q, held_duty_q, 1'b0, 1'b1));
                end
            end
        endcase
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            drive_results_due.delete();
            count_q      = '0;
            goal_q       = '0;
            dir_q        = DIR_OFF;
            held_duty_q  = '0;
            margin_q     = MARGIN_RST;
            inv_zero_q   = INV_ZERO_RST;
            rate_q       = RATE_RST;
            brake_duty_q = BRAKE_DUTY_RST;
            mismatches   = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (drive_results_due.size() == 0) begin
                    mismatches++;
                    $display("%0t unexpected result: expected none actual %h last %b",
                             $time, m_tdata, m_tlast);
                end else begin
                    want = drive_results_due.pop_front();
                    compare_field("in_fwd", want.in_fwd, m_tdata[0]);
                    compare_field("in_rev", want.in_rev, m_tdata[1]);
                    compare_field("duty", want.duty, m_tdata[9:2]);
                    compare_field("timed_pulse", want.timed_pulse, m_tdata[10]);
                    compare_field("position", want.position, m_tdata[42:11]);
                    compare_field("target_now", want.target_now, m_tdata[74:43]);
                    compare_field("last", want.last, m_tlast);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MARGIN:     margin_q     = cfg_data[MARGIN_W-1:0];
                    REG_INV_ZERO:   inv_zero_q   = cfg_data[IZ_W-1:0];
                    REG_RATE_Q8:    rate_q       = cfg_data[RATE_W-1:0];
                    REG_BRAKE_DUTY: brake_duty_q = cfg_data[DUTY_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                advance_drive(s_tuser, s_tdata[0], s_tdata[1], s_tdata[33:2], s_tdata[49:34]);
        end
        outstanding = drive_results_due.size();
    end

endmodule

/* tb/quadrature_position_drive_top_tb.sv */
`timescale 1ns / 1ps

module quadrature_position_drive_top_tb;
    import qpd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SEGMENTS     = 8;
    localparam int SEGMENT_ITEMS = 235;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    // enc_a, enc_b, target_pos, speed_req
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    // command
    logic [S_TUSER_W-1:0] s_tuser   = CMD_ENC_A;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    // in_fwd, in_rev, duty, timed_pulse, position, target_now
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_MARGIN;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    int   mismatches;
    int   outstanding;
    int   cycles       = 0;
    int   idle_pct     = 0;
    int   stall_pct    = 0;
    int   items_sent   = 0;
    bit   hold_toggle  = 1'b0;
    bit   hold_seen    = 1'b0;
    int   hold_left    = 0;
    bit   shaft_a      = 1'b0;
    bit   shaft_b      = 1'b0;
    bit   held_once    = 1'b0;

    always #5 aclk = ~aclk;

    quadrature_position_drive_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    quadrature_position_drive_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_seen != hold_toggle) begin
            hold_seen <= hold_toggle;
            hold_left <= 200;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic offer_item(input logic [1:0] cmd, input logic a, input logic b,
                              input logic [31:0] tgt, input logic [15:0] spd);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'd0, spd, tgt, b, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // one well-formed quadrature transition in the given direction
    task automatic turn_shaft(input bit up);
        if ((shaft_a == shaft_b) == up) begin
            shaft_b = ~shaft_b;
            offer_item(CMD_ENC_B, shaft_a, shaft_b, $urandom, 16'($urandom));
        end else begin
            shaft_a = ~shaft_a;
            offer_item(CMD_ENC_A, shaft_a, shaft_b, $urandom, 16'($urandom));
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic program_registers(input int margin, input int inv_zero, input int rate,
                                     input int brake_duty, input int brake_ms);
        cfg_write(REG_MARGIN, {4'($urandom), 16'(margin)});
        cfg_write(REG_INV_ZERO, 20'(inv_zero));
        cfg_write(REG_RATE_Q8, {8'($urandom), 12'(rate)});
        cfg_write(REG_BRAKE_DUTY, {12'($urandom), 8'(brake_duty)});
        cfg_write(REG_BRAKE_MS, {12'($urandom), 8'(brake_ms)});
        cfg_write(REG_BRAKE_MS + 3'(1 + $urandom_range(0, 2)), 20'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic random_item();
        int          pick;
        int          steps;
        bit          up;
        logic [31:0] tgt;
        logic [15:0] spd;
        pick = $urandom_range(99);
        if (pick < 45) begin
            steps = $urandom_range(1, 8);
            up    = 1'($urandom_range(1));
            repeat (steps) turn_shaft(up);
        end else if (pick < 60) begin
            shaft_a = 1'($urandom_range(1));
            shaft_b = 1'($urandom_range(1));
            offer_item($urandom_range(1) ? CMD_ENC_B : CMD_ENC_A, shaft_a, shaft_b,
                       $urandom, 16'($urandom));
        end else if (pick < 75) begin
            tgt = ($urandom_range(99) < 85) ? $urandom_range(0, 200) - 100 : $urandom;
            offer_item(CMD_SET, 1'($urandom_range(1)), 1'($urandom_range(1)), tgt,
                       16'($urandom));
        end else begin
            spd = ($urandom_range(99) < 70) ? 16'($urandom) : 16'($urandom_range(0, 600) - 300);
            offer_item(CMD_DRIVE, 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom, spd);
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // brake from standstill, then saturation and smallest duty
        offer_item(CMD_DRIVE, 1'b0, 1'b0, 32'd0, 16'd0);
        offer_item(CMD_SET, 1'b1, 1'b1, 32'd1000, 16'hFFFF);
        offer_item(CMD_DRIVE, 1'b0, 1'b0, 32'hFFFF_FFFF, 16'h7FFF);
        offer_item(CMD_DRIVE, 1'b1, 1'b1, 32'd0, 16'h8000);
        offer_item(CMD_DRIVE, 1'b0, 1'b1, 32'd0, 16'd1);
        // every direction rule on both channels
        offer_item(CMD_ENC_A, 1'b0, 1'b0, 32'd0, 16'd0);
        offer_item(CMD_ENC_A, 1'b1, 1'b0, 32'd0, 16'd0);
        offer_item(CMD_ENC_B, 1'b1, 1'b0, 32'd0, 16'd0);
        offer_item(CMD_ENC_B, 1'b1, 1'b1, 32'd0, 16'd0);
        // extreme targets
        offer_item(CMD_SET, 1'b0, 1'b0, 32'h8000_0000, 16'd0);
        offer_item(CMD_DRIVE, 1'b0, 1'b0, 32'd0, 16'd300);
        offer_item(CMD_SET, 1'b0, 1'b0, 32'h7FFF_FFFF, 16'd0);
        offer_item(CMD_DRIVE, 1'b0, 1'b0, 32'd0, -16'sd200);
        // plug brake out of forward and out of reverse
        offer_item(CMD_SET, 1'b0, 1'b0, 32'd3, 16'd0);
        offer_item(CMD_DRIVE, 1'b0, 1'b0, 32'd0, 16'd7);
        offer_item(CMD_SET, 1'b0, 1'b0, -32'sd20, 16'd0);
        offer_item(CMD_DRIVE, 1'b0, 1'b0, 32'd0, 16'd5);
        offer_item(CMD_SET, 1'b0, 1'b0, 32'd0, 16'd0);
        offer_item(CMD_DRIVE, 1'b0, 1'b0, 32'd0, 16'd0);

        // zero margin at target, then the reverse zero offset and its return
        drain();
        program_registers(0, 6, 4095, 255, 255);
        offer_item(CMD_DRIVE, 1'b0, 1'b0, 32'd0, 16'd100);
        repeat (4) turn_shaft(1'b1);
        offer_item(CMD_DRIVE, 1'b0, 1'b0, 32'd0, 16'd1);
        drain();
        cfg_write(REG_MARGIN, 20'd5);
        cfg_valid <= 1'b0;
        offer_item(CMD_DRIVE, 1'b0, 1'b0, 32'd0, 16'd1);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            drain();
            case (seg)
                0:       program_registers(16'hFFFF, 20'hFFFFF, 12'hFFF, 8'hFF, 8'hFF);
                1:       program_registers(0, 0, 0, 0, 0);
                default: program_registers($urandom_range(0, 120), $urandom_range(0, 150),
                                           $urandom_range(0, 4095), $urandom_range(0, 255),
                                           $urandom_range(0, 255));
            endcase
            case (seg % 4)
                0: begin idle_pct <= 0;  stall_pct <= 0;  end
                1: begin idle_pct <= 74; stall_pct <= 0;  end
                2: begin idle_pct <= 0;  stall_pct <= 74; end
                default: begin idle_pct <= 15; stall_pct <= 15; end
            endcase
            items_sent = 0;
            while (items_sent < SEGMENT_ITEMS) begin
                if (!held_once && items_sent >= 60) begin
                    held_once = 1'b1;
                    hold_toggle <= ~hold_toggle;
                end
                random_item();
            end
        end

        drain();
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
